[rtl/rgba_source_over_blend_defines.svh]
// Assertion macros shared by the blend pipeline.
// Each macro samples on clk and is disabled while rst is high.
`ifndef RGBA_SOURCE_OVER_BLEND_DEFINES_SVH
`define RGBA_SOURCE_OVER_BLEND_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define SOB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define SOB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sob_pkg.sv]
package sob_pkg;

  // Full channel value and the rounding offset used with it.
  localparam logic [7:0] CH_MAX     = 8'd255;
  localparam logic [7:0] ROUND_HALF = 8'd127;

  // Divider depth: two quotient bits per stage cover the eight-bit quotient.
  localparam int DIV_STAGES = 4;

  // One source and one destination pixel, straight alpha.
  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_a;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;
  } pair_t;

  // The blended destination pixel.
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } blend_t;

  // How the result is formed once the effective alpha is known.
  typedef enum logic [2:0] {
    MODE_PASS = 3'b001,
    MODE_COPY = 3'b010,
    MODE_MIX  = 3'b100
  } mode_t;

  // Pixel pair with its effective source alpha.
  typedef struct packed {
    pair_t      pair;
    logic [7:0] ea;
  } alpha_t;

  // Everything the divider needs: numerators (rounding already added),
  // the combined alpha divisor and the result for the non-mixing modes.
  typedef struct packed {
    mode_t            mode;
    blend_t           base;
    logic [15:0]      an;
    logic [2:0][23:0] num;
  } wgt_t;

  // Floor division by 255 for x up to 255*255+127. With q = x/256 the
  // remainder x - 255q equals x[7:0] + q, which stays below 510, so a
  // single correction step is enough.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [8:0] r;
    r = {1'b0, x[7:0]} + {1'b0, x[15:8]};
    if (r >= {1'b0, CH_MAX}) begin
      return x[15:8] + 8'd1;
    end else begin
      return x[15:8];
    end
  endfunction

  // Multiply by 255 as a shift and a subtract.
  function automatic logic [23:0] times255(input logic [15:0] x);
    return {x, 8'd0} - {8'd0, x};
  endfunction

  // One restoring division step: try to subtract the divisor shifted to
  // the quotient bit position. Returns the quotient bit over the remainder.
  function automatic logic [24:0] div_step(input logic [23:0] rem,
                                           input logic [15:0] an,
                                           input logic [2:0]  shift);
    logic [23:0] d;
    d = {8'd0, an} << shift;
    if (rem >= d) begin
      return {1'b1, rem - d};
    end else begin
      return {1'b0, rem};
    end
  endfunction

endpackage

[rtl/rgba_source_over_blend.sv]
// Source-over blend of one straight-alpha RGBA8 source pixel onto one
// straight-alpha RGBA8 destination pixel, scaled by a global opacity
// register (reset 255). The block takes one pixel pair per clock while
// the output is not stalled and returns one blended pixel per pair, in
// order. A pair passes through the effective alpha stages, then the
// weight product and numerator stages, then the divider, which resolves
// two quotient bits per stage. Each stage holds its transfer while
// stalled and empty stages fill behind it, so a stall on the output
// side loses no work. Write the opacity register only while no pixel
// is in flight.
module rgba_source_over_blend (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata,
  input  logic            pair_valid,
  output logic            pair_stall,
  input  sob_pkg::pair_t  pair,
  output logic            blend_valid,
  input  logic            blend_stall,
  output sob_pkg::blend_t blend
);

  `include "rgba_source_over_blend_defines.svh"

  logic            opacity;
  logic [7:0]      opacity_q;
  logic            pair_ready;
  logic            alpha_valid;
  logic            alpha_ready;
  sob_pkg::alpha_t alpha;
  logic            wgt_valid;
  logic            wgt_ready;
  sob_pkg::wgt_t   wgt;
  logic            wgt_held;
  logic            full_src;
  logic            ea_full;

  // Opacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      opacity_q <= sob_pkg::CH_MAX;
    end else if (cfg_we) begin
      opacity_q <= cfg_wdata;
    end
  end

  // Flag that the opacity is at its full value, used by the checks below.
  assign opacity = (opacity_q == sob_pkg::CH_MAX);

  assign pair_stall = !pair_ready;

  sob_alpha u_alpha (
    .clk       (clk),
    .rst       (rst),
    .opacity   (opacity_q),
    .in_valid  (pair_valid),
    .in_ready  (pair_ready),
    .in_data   (pair),
    .out_valid (alpha_valid),
    .out_ready (alpha_ready),
    .out_data  (alpha)
  );

  sob_weight u_weight (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (alpha_valid),
    .in_ready  (alpha_ready),
    .in_data   (alpha),
    .out_valid (wgt_valid),
    .out_ready (wgt_ready),
    .out_data  (wgt)
  );

  sob_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (wgt_valid),
    .in_ready  (wgt_ready),
    .in_data   (wgt),
    .out_valid (blend_valid),
    .out_ready (!blend_stall),
    .out_data  (blend)
  );

  // Terms used by the checks below.
  assign wgt_held = wgt_valid && !wgt_ready;
  assign full_src = alpha_valid && opacity && (alpha.pair.src_a == sob_pkg::CH_MAX);
  assign ea_full  = (alpha.ea == sob_pkg::CH_MAX);

  // A write lands in the opacity register on the next cycle.
  `SOB_ASSERT_NEXT(a_cfg_write, cfg_we, opacity_q == $past(cfg_wdata), "opacity write lost")

  // With the output free, every stage moves, so the input cannot stall.
  `SOB_ASSERT_NOW(a_no_stall, !blend_stall, !pair_stall, "input stalled with output free")

  // A weight transfer held back by the divider stays put.
  `SOB_ASSERT_NEXT(a_wgt_hold, wgt_held, wgt_valid && $stable(wgt), "weight transfer dropped")

  // Full effective alpha at full opacity needs the source alpha at full
  // value to reach the copy path; the alpha stage must reflect that.
  `SOB_ASSERT_NOW(a_full_alpha, full_src, ea_full, "effective alpha wrong at full opacity")

endmodule

[rtl/sob_alpha.sv]
// Two-stage front end: scales the source alpha by the opacity register
// and divides by 255 with rounding.
module sob_alpha (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           opacity,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sob_pkg::pair_t       in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sob_pkg::alpha_t      out_data
);

  typedef struct packed {
    sob_pkg::pair_t pair;
    logic [15:0]    x;
  } a1_t;

  logic            v1;
  logic            v2;
  logic            adv1;
  logic            adv2;
  a1_t             s1;
  a1_t             s1_next;
  sob_pkg::alpha_t s2;
  sob_pkg::alpha_t s2_next;

  // A stage takes a new transfer when it is empty or its contents move on.
  assign adv2     = !v2 || out_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  // Stage 1: alpha times opacity plus the rounding offset.
  always_comb begin
    s1_next.pair = in_data;
    s1_next.x    = ({8'd0, in_data.src_a} * {8'd0, opacity}) +
                   {8'd0, sob_pkg::ROUND_HALF};
  end

  // Stage 2: divide by 255.
  always_comb begin
    s2_next.pair = s1.pair;
    s2_next.ea   = sob_pkg::div255(s1.x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1 <= s1_next;
    end
    if (adv2 && v1) begin
      s2 <= s2_next;
    end
  end

  assign out_valid = v2;
  assign out_data  = s2;

endmodule

[rtl/sob_weight.sv]
// Three-stage weighting: picks the blend mode and forms the combined
// alpha, the rounded per-channel numerators and the output alpha.
module sob_weight (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sob_pkg::alpha_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sob_pkg::wgt_t    out_data
);

  typedef struct packed {
    sob_pkg::mode_t   mode;
    sob_pkg::pair_t   pair;
    logic [2:0][15:0] ps;
    logic [15:0]      dainv;
    logic [15:0]      ea255;
  } w1_t;

  typedef struct packed {
    sob_pkg::mode_t   mode;
    sob_pkg::pair_t   pair;
    logic [15:0]      an;
    logic [2:0][23:0] sterm;
    logic [2:0][23:0] dterm;
  } w2_t;

  logic          v1;
  logic          v2;
  logic          v3;
  logic          adv1;
  logic          adv2;
  logic          adv3;
  w1_t           s1;
  w1_t           s1_next;
  w2_t           s2;
  w2_t           s2_next;
  sob_pkg::wgt_t s3;
  sob_pkg::wgt_t s3_next;
  logic [7:0]    inv;
  logic [15:0]   an_round;

  assign adv3     = !v3 || out_ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  // Stage 1: mode decision and the first round of 8x8 products.
  assign inv = sob_pkg::CH_MAX - in_data.ea;

  always_comb begin
    if (in_data.ea == 8'd0) begin
      s1_next.mode = sob_pkg::MODE_PASS;
    end else if (in_data.ea == sob_pkg::CH_MAX) begin
      s1_next.mode = sob_pkg::MODE_COPY;
    end else begin
      s1_next.mode = sob_pkg::MODE_MIX;
    end
    s1_next.pair  = in_data.pair;
    s1_next.ps[0] = {8'd0, in_data.pair.src_red}   * {8'd0, in_data.ea};
    s1_next.ps[1] = {8'd0, in_data.pair.src_green} * {8'd0, in_data.ea};
    s1_next.ps[2] = {8'd0, in_data.pair.src_blue}  * {8'd0, in_data.ea};
    s1_next.dainv = {8'd0, in_data.pair.dst_alpha} * {8'd0, inv};
    s1_next.ea255 = {in_data.ea, 8'd0} - {8'd0, in_data.ea};
  end

  // Stage 2: combined alpha and the second round of products.
  always_comb begin
    s2_next.mode     = s1.mode;
    s2_next.pair     = s1.pair;
    s2_next.an       = s1.ea255 + s1.dainv;
    s2_next.sterm[0] = sob_pkg::times255(s1.ps[0]);
    s2_next.sterm[1] = sob_pkg::times255(s1.ps[1]);
    s2_next.sterm[2] = sob_pkg::times255(s1.ps[2]);
    s2_next.dterm[0] = {16'd0, s1.pair.dst_red}   * {8'd0, s1.dainv};
    s2_next.dterm[1] = {16'd0, s1.pair.dst_green} * {8'd0, s1.dainv};
    s2_next.dterm[2] = {16'd0, s1.pair.dst_blue}  * {8'd0, s1.dainv};
  end

  // Stage 3: numerators with half the divisor added, and the base result:
  // the pixel for the pass-through and copy modes, the alpha for mixing.
  assign an_round = s2.an + {8'd0, sob_pkg::ROUND_HALF};

  always_comb begin
    s3_next.mode = s2.mode;
    s3_next.an   = s2.an;
    for (int c = 0; c < 3; c++) begin
      s3_next.num[c] = s2.sterm[c] + s2.dterm[c] + {9'd0, s2.an[15:1]};
    end
    case (s2.mode)
      sob_pkg::MODE_PASS: begin
        s3_next.base.out_red   = s2.pair.dst_red;
        s3_next.base.out_green = s2.pair.dst_green;
        s3_next.base.out_blue  = s2.pair.dst_blue;
        s3_next.base.out_alpha = s2.pair.dst_alpha;
      end
      sob_pkg::MODE_COPY: begin
        s3_next.base.out_red   = s2.pair.src_red;
        s3_next.base.out_green = s2.pair.src_green;
        s3_next.base.out_blue  = s2.pair.src_blue;
        s3_next.base.out_alpha = sob_pkg::CH_MAX;
      end
      default: begin
        s3_next.base.out_red   = 8'd0;
        s3_next.base.out_green = 8'd0;
        s3_next.base.out_blue  = 8'd0;
        s3_next.base.out_alpha = sob_pkg::div255(an_round);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1 <= s1_next;
    end
    if (adv2 && v1) begin
      s2 <= s2_next;
    end
    if (adv3 && v2) begin
      s3 <= s3_next;
    end
  end

  assign out_valid = v3;
  assign out_data  = s3;

endmodule

[rtl/sob_div.sv]
// Four-stage restoring divider, two quotient bits per stage for all three
// color channels at once. The quotient never exceeds 255, so eight bits
// starting at the divisor shifted by seven cover it.
module sob_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sob_pkg::wgt_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output sob_pkg::blend_t out_data
);

  typedef struct packed {
    sob_pkg::mode_t   mode;
    sob_pkg::blend_t  base;
    logic [15:0]      an;
    logic [2:0][23:0] rem;
    logic [2:0][7:0]  quo;
  } divs_t;

  logic [sob_pkg::DIV_STAGES-1:0] v;
  logic [sob_pkg::DIV_STAGES:0]   adv;
  divs_t                          st [sob_pkg::DIV_STAGES];
  divs_t                          first;

  // Divider entry: remainder starts at the numerator, quotient empty.
  always_comb begin
    first.mode = in_data.mode;
    first.base = in_data.base;
    first.an   = in_data.an;
    first.rem  = in_data.num;
    first.quo  = '0;
  end

  assign adv[sob_pkg::DIV_STAGES] = out_ready;
  assign in_ready                 = adv[0];

  for (genvar g = 0; g < sob_pkg::DIV_STAGES; g++) begin : g_stage
    divs_t       prev;
    divs_t       st_next;
    logic        prev_v;
    logic [24:0] s1;
    logic [24:0] s2;

    if (g == 0) begin : g_head
      assign prev   = first;
      assign prev_v = in_valid;
    end else begin : g_body
      assign prev   = st[g-1];
      assign prev_v = v[g-1];
    end

    assign adv[g] = !v[g] || adv[g+1];

    // Two dependent subtract-and-compare steps per channel.
    always_comb begin
      st_next = prev;
      s1      = '0;
      s2      = '0;
      for (int c = 0; c < 3; c++) begin
        s1 = sob_pkg::div_step(prev.rem[c], prev.an, 3'(7 - 2*g));
        s2 = sob_pkg::div_step(s1[23:0], prev.an, 3'(6 - 2*g));
        st_next.quo[c][7 - 2*g] = s1[24];
        st_next.quo[c][6 - 2*g] = s2[24];
        st_next.rem[c]          = s2[23:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g] <= 1'b0;
      end else if (adv[g]) begin
        v[g] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[g] && prev_v) begin
        st[g] <= st_next;
      end
    end
  end

  // Mixed pixels take the quotients; the other modes use the base pixel.
  always_comb begin
    out_data = st[sob_pkg::DIV_STAGES-1].base;
    if (st[sob_pkg::DIV_STAGES-1].mode == sob_pkg::MODE_MIX) begin
      out_data.out_red   = st[sob_pkg::DIV_STAGES-1].quo[0];
      out_data.out_green = st[sob_pkg::DIV_STAGES-1].quo[1];
      out_data.out_blue  = st[sob_pkg::DIV_STAGES-1].quo[2];
    end
  end

  assign out_valid = v[sob_pkg::DIV_STAGES-1];

endmodule
